[src/qpm_pkg.sv]
// Shared constants, types and lookup functions of the quaternion-to-pointer-motion block.
// No dependencies; every other file of the block refers to this package by scoped names.
`default_nettype none
package qpm_pkg;

  localparam int QW      = 16;   // quaternion component width, Q2.14
  localparam int RPW     = 34;   // exact component of conj(a)*b
  localparam int SW      = 20;   // rounded component of conj(origin)*q
  localparam int A_W     = 35;   // multiplier operand A
  localparam int B_W     = 21;   // multiplier operand B
  localparam int P_W     = A_W + B_W;
  localparam int CW      = 42;   // CORDIC vector width
  localparam int ZW      = 20;   // angle width, radians * 65536
  localparam int DW      = 21;   // yaw minus dead zone
  localparam int SUM_W   = 44;   // accumulator sums
  localparam int FRAC_W  = 17;   // fraction accumulator
  localparam int DZ_W    = 18;
  localparam int G_W     = 16;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;
  localparam int RPT_W   = 8;

  localparam int CORDIC_STEPS_DEF = 16;
  localparam int PENDING_BITS_DEF = 24;

  localparam logic [DZ_W-1:0] DEAD_ZONE_RST  = DZ_W'(25736);
  localparam logic [G_W-1:0]  SPEED_GAIN_RST = G_W'(1600);
  localparam logic signed [QW-1:0] QUAT_ONE  = QW'(16384);
  localparam logic signed [ZW-1:0] HALF_PI   = ZW'(102944);

  localparam logic REG_DEAD_ZONE  = 1'b0;
  localparam logic REG_SPEED_GAIN = 1'b1;
  localparam logic CMD_PUSH       = 1'b0;
  localparam logic CMD_DRAIN      = 1'b1;

  typedef struct packed {
    logic vld;
    logic neg;
    logic clr;
  } mac_ctl_t;

  typedef struct packed {
    logic [1:0] bidx;
    logic       neg;
  } qterm_t;

  // Term j of component c of conj(a)*b: a[j] times b[bidx], subtracted when neg.
  function automatic qterm_t quat_term(input logic [1:0] c, input logic [1:0] j);
    qterm_t t;
    t.bidx = 2'(c ^ j);
    case (c)
      2'd0:    t.neg = 1'b0;
      2'd1:    t.neg = (j == 2'd1) || (j == 2'd2);
      2'd2:    t.neg = (j == 2'd2) || (j == 2'd3);
      2'd3:    t.neg = (j == 2'd1) || (j == 2'd3);
      default: t.neg = 1'b0;
    endcase
    return t;
  endfunction

  function automatic logic signed [ZW-1:0] atan_lut(input logic [4:0] i);
    logic signed [ZW-1:0] v;
    case (i)
      5'd0:    v = ZW'(51472);
      5'd1:    v = ZW'(30386);
      5'd2:    v = ZW'(16055);
      5'd3:    v = ZW'(8150);
      5'd4:    v = ZW'(4091);
      5'd5:    v = ZW'(2047);
      5'd6:    v = ZW'(1024);
      5'd7:    v = ZW'(512);
      5'd8:    v = ZW'(256);
      5'd9:    v = ZW'(128);
      5'd10:   v = ZW'(64);
      5'd11:   v = ZW'(32);
      5'd12:   v = ZW'(16);
      5'd13:   v = ZW'(8);
      5'd14:   v = ZW'(4);
      5'd15:   v = ZW'(2);
      5'd16:   v = ZW'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/qpm_if.sv]
// Handshake interfaces for the sample input and the report output channels.
// Depends on qpm_pkg for field widths.
`default_nettype none
interface qpm_sample_if;
  logic                             valid;
  logic                             ready;
  logic                             command;
  logic signed [qpm_pkg::QW-1:0]    quat_w;
  logic signed [qpm_pkg::QW-1:0]    quat_x;
  logic signed [qpm_pkg::QW-1:0]    quat_y;
  logic signed [qpm_pkg::QW-1:0]    quat_z;
  logic                             set_origin;
  logic signed [qpm_pkg::RPT_W-1:0] report_x;
  logic signed [qpm_pkg::RPT_W-1:0] report_y;

  modport source (output valid, command, quat_w, quat_x, quat_y, quat_z, set_origin,
                  report_x, report_y, input ready);
  modport sink (input valid, command, quat_w, quat_x, quat_y, quat_z, set_origin,
                report_x, report_y, output ready);
endinterface

interface qpm_report_if;
  logic                             valid;
  logic                             ready;
  logic signed [qpm_pkg::RPT_W-1:0] new_x;
  logic signed [qpm_pkg::RPT_W-1:0] new_y;
  logic [1:0]                       axes_moved;

  modport source (output valid, new_x, new_y, axes_moved, input ready);
  modport sink (input valid, new_x, new_y, axes_moved, output ready);
endinterface
`default_nettype wire

[src/qpm_mac.sv]
// Shared multiply-accumulate unit: registered product, then signed accumulate.
// Depends on qpm_pkg for operand widths and the control struct.
`default_nettype none
module qpm_mac (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire qpm_pkg::mac_ctl_t             ctl_i,
  input  wire logic signed [qpm_pkg::A_W-1:0] a_i,
  input  wire logic signed [qpm_pkg::B_W-1:0] b_i,
  output logic signed [qpm_pkg::P_W-1:0]      acc_o
);
  qpm_pkg::mac_ctl_t                 ctl_q;
  logic signed [qpm_pkg::P_W-1:0]    prod_q;
  logic signed [qpm_pkg::P_W-1:0]    acc_q, acc_d, base;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  always_comb begin
    base  = ctl_q.clr ? '0 : acc_q;
    acc_d = ctl_q.neg ? base - prod_q : base + prod_q;
  end

  always_ff @(posedge clk_i) begin
    prod_q <= qpm_pkg::P_W'(a_i) * qpm_pkg::P_W'(b_i);
    if (ctl_q.vld) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;
endmodule
`default_nettype wire

[src/qpm_cordic.sv]
// Iterative CORDIC atan2 in vectoring mode, one micro-rotation per cycle.
// Depends on qpm_pkg for widths, the quarter-turn constant and the arctangent table.
`default_nettype none
module qpm_cordic #(
  parameter int CORDIC_STEPS = qpm_pkg::CORDIC_STEPS_DEF
) (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 start_i,
  input  wire logic signed [qpm_pkg::CW-1:0]  y_i,
  input  wire logic signed [qpm_pkg::CW-1:0]  x_i,
  output logic                                done_o,
  output logic signed [qpm_pkg::ZW-1:0]       z_o
);
  localparam int IW = $clog2(CORDIC_STEPS);

  logic                           busy_q, done_q;
  logic [IW-1:0]                  i_q;
  logic signed [qpm_pkg::CW-1:0]  x_q, y_q, xs, ys;
  logic signed [qpm_pkg::ZW-1:0]  z_q, ang;

  assign xs  = x_q >>> i_q;
  assign ys  = y_q >>> i_q;
  assign ang = qpm_pkg::atan_lut(5'(i_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        i_q    <= '0;
      end else if (busy_q) begin
        i_q <= i_q + IW'(1);
        if (i_q == IW'(CORDIC_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // A vector in the left half-plane is first turned by a quarter turn.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      if (x_i < 0) begin
        if (y_i >= 0) begin
          x_q <= y_i;
          y_q <= -x_i;
          z_q <= qpm_pkg::HALF_PI;
        end else begin
          x_q <= -y_i;
          y_q <= x_i;
          z_q <= -qpm_pkg::HALF_PI;
        end
      end else begin
        x_q <= x_i;
        y_q <= y_i;
        z_q <= '0;
      end
    end else if (busy_q) begin
      if (y_q > 0) begin
        x_q <= x_q + ys;
        y_q <= y_q - xs;
        z_q <= z_q + ang;
      end else if (y_q < 0) begin
        x_q <= x_q - ys;
        y_q <= y_q + xs;
        z_q <= z_q - ang;
      end
    end
  end

  assign done_o = done_q;
  assign z_o    = z_q;
endmodule
`default_nettype wire

[src/quaternion_to_pointer_motion_top.sv]
// Top level: sequencer, state, configuration registers and the report drain.
// Depends on qpm_pkg, qpm_if, qpm_mac and qpm_cordic.
//
//  channel  | direction | handshake          | carries
//  sample_i | in        | valid/ready        | command, quaternion, set_origin, report
//  report_o | out       | valid/ready        | new_x, new_y, axes_moved
//  apb      | in        | psel/penable/pready| dead_zone, speed_gain
//
// A motion sample runs 32 terms through the one shared multiplier, then the CORDIC
// loop, then the rate term. The first sample and set-origin samples leave the
// sequencer idle; a drain computes the report and then holds it until its transfer.
// Input is not ready while busy.
// Reset is asynchronous and loads identity quaternions and clears all counters.
`default_nettype none
module quaternion_to_pointer_motion_top #(
  parameter int CORDIC_STEPS = qpm_pkg::CORDIC_STEPS_DEF,
  parameter int PENDING_BITS = qpm_pkg::PENDING_BITS_DEF
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  qpm_sample_if.sink                        sample_i,
  qpm_report_if.source                      report_o,
  input  wire                               psel,
  input  wire                               penable,
  input  wire                               pwrite,
  input  wire [qpm_pkg::CFG_AW-1:0]         paddr,
  input  wire [qpm_pkg::CFG_DW-1:0]         pwdata,
  output logic [qpm_pkg::CFG_DW-1:0]        prdata,
  output logic                              pready
);
  localparam int QW = qpm_pkg::QW;
  localparam int PB = PENDING_BITS;
  localparam int SUM_W = qpm_pkg::SUM_W;
  localparam int P_W = qpm_pkg::P_W;
  localparam int A_W = qpm_pkg::A_W;
  localparam int B_W = qpm_pkg::B_W;
  localparam int RPT_WL = qpm_pkg::RPT_W;
  localparam logic signed [SUM_W-1:0] P_HI = SUM_W'((64'sd1 <<< (PB - 1)) - 64'sd1);
  localparam logic signed [SUM_W-1:0] P_LO = SUM_W'(-(64'sd1 <<< (PB - 1)));
  localparam logic signed [P_W-1:0] HALF14 = P_W'(8192);
  localparam logic signed [P_W-1:0] HALF11 = P_W'(1024);
  localparam logic [5:0] LAST_CALC = 6'd34;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_CORD  = 6'b000100,
    ST_RATE  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [5:0] step_q;

  logic [qpm_pkg::DZ_W-1:0] dz_q;
  logic [qpm_pkg::G_W-1:0]  g_q;

  logic signed [QW-1:0] prev_q [4];
  logic signed [QW-1:0] orig_q [4];
  logic signed [QW-1:0] q_q [4];
  logic signed [QW-1:0] q_in [4];
  logic                 first_q;
  logic signed [qpm_pkg::FRAC_W-1:0] frac_q [2];
  logic signed [PB-1:0] pend_q [2];

  logic signed [qpm_pkg::RPW-1:0] r3_q, r1_q;
  logic signed [qpm_pkg::SW-1:0]  s_q [4];
  logic signed [SUM_W-1:0]        hx_q, vt_q;
  logic signed [qpm_pkg::CW-1:0]  vx_q, vy_q, cord_y;
  logic signed [RPT_WL-1:0]       rx_q, ry_q;
  logic signed [RPT_WL-1:0]       nx_q, ny_q;
  logic [1:0]                     moved_q;

  logic in_acc, cfg_wr, cord_done;
  logic signed [qpm_pkg::ZW-1:0] yaw;
  logic signed [P_W-1:0] acc, acc_r14, acc_r11;
  qpm_pkg::mac_ctl_t mac_ctl;
  logic signed [A_W-1:0] mac_a;
  logic signed [B_W-1:0] mac_b, gs;
  logic signed [qpm_pkg::DW-1:0] yw, dzs, rate_a;

  assign q_in[0] = sample_i.quat_w;
  assign q_in[1] = sample_i.quat_x;
  assign q_in[2] = sample_i.quat_y;
  assign q_in[3] = sample_i.quat_z;

  assign in_acc = sample_i.valid && sample_i.ready;
  assign sample_i.ready = (state_q == ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == qpm_pkg::REG_SPEED_GAIN) ? qpm_pkg::CFG_DW'(g_q)
                                                       : qpm_pkg::CFG_DW'(dz_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_q <= qpm_pkg::DEAD_ZONE_RST;
      g_q  <= qpm_pkg::SPEED_GAIN_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == qpm_pkg::REG_DEAD_ZONE) begin
        dz_q <= pwdata[qpm_pkg::DZ_W-1:0];
      end else begin
        g_q <= pwdata[qpm_pkg::G_W-1:0];
      end
    end
  end

  // Shared multiplier schedule.
  assign gs  = {{(B_W - qpm_pkg::G_W){1'b0}}, g_q};
  assign yw  = qpm_pkg::DW'(yaw);
  assign dzs = {{(qpm_pkg::DW - qpm_pkg::DZ_W){1'b0}}, dz_q};

  always_comb begin
    if (yw > dzs) begin
      rate_a = yw - dzs;
    end else if (yw < -dzs) begin
      rate_a = yw + dzs;
    end else begin
      rate_a = '0;
    end
  end

  always_comb begin
    logic [2:0] grp;
    logic [1:0] j, comp;
    qpm_pkg::qterm_t term;
    grp = step_q[4:2];
    j = step_q[1:0];
    case (grp)
      3'd0:    comp = 2'd3;
      3'd1:    comp = 2'd1;
      default: comp = 2'(grp - 3'd2);
    endcase
    term = qpm_pkg::quat_term(comp, j);
    mac_ctl = '0;
    mac_a = '0;
    mac_b = '0;
    if (state_q == ST_CALC) begin
      if (step_q < 6'd24) begin
        mac_ctl = '{vld: 1'b1, neg: term.neg, clr: (j == 2'd0)};
        mac_a = (grp < 3'd2) ? A_W'(prev_q[j]) : A_W'(orig_q[j]);
        mac_b = B_W'(q_q[term.bidx]);
      end else begin
        case (step_q)
          6'd24: begin mac_ctl = '{1'b1, 1'b1, 1'b1}; mac_a = A_W'(r3_q); mac_b = gs; end
          6'd25: begin mac_ctl = '{1'b1, 1'b1, 1'b1}; mac_a = A_W'(r1_q); mac_b = gs; end
          6'd26: begin mac_ctl = '{1'b1, 1'b0, 1'b1}; mac_a = A_W'(s_q[1]); mac_b = B_W'(s_q[2]); end
          6'd27: begin mac_ctl = '{1'b1, 1'b1, 1'b0}; mac_a = A_W'(s_q[0]); mac_b = B_W'(s_q[3]); end
          6'd28: begin mac_ctl = '{1'b1, 1'b0, 1'b1}; mac_a = A_W'(s_q[0]); mac_b = B_W'(s_q[0]); end
          6'd29: begin mac_ctl = '{1'b1, 1'b1, 1'b0}; mac_a = A_W'(s_q[1]); mac_b = B_W'(s_q[1]); end
          6'd30: begin mac_ctl = '{1'b1, 1'b0, 1'b0}; mac_a = A_W'(s_q[2]); mac_b = B_W'(s_q[2]); end
          6'd31: begin mac_ctl = '{1'b1, 1'b1, 1'b0}; mac_a = A_W'(s_q[3]); mac_b = B_W'(s_q[3]); end
          default: mac_ctl = '0;
        endcase
      end
    end else if ((state_q == ST_RATE) && (step_q == 6'd0)) begin
      mac_ctl = '{vld: 1'b1, neg: 1'b0, clr: 1'b1};
      mac_a = A_W'(rate_a);
      mac_b = gs;
    end
  end

  qpm_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (mac_ctl),
    .a_i    (mac_a),
    .b_i    (mac_b),
    .acc_o  (acc)
  );

  assign cord_y = -vx_q;

  qpm_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i ((state_q == ST_CALC) && (step_q == LAST_CALC)),
    .y_i     (cord_y),
    .x_i     (vy_q),
    .done_o  (cord_done),
    .z_o     (yaw)
  );

  assign acc_r14 = (acc + HALF14) >>> 14;
  assign acc_r11 = (acc + HALF11) >>> 11;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      case (step_q)
        6'd5:  r3_q <= acc[qpm_pkg::RPW-1:0];
        6'd9:  r1_q <= acc[qpm_pkg::RPW-1:0];
        6'd13: s_q[0] <= acc_r14[qpm_pkg::SW-1:0];
        6'd17: s_q[1] <= acc_r14[qpm_pkg::SW-1:0];
        6'd21: s_q[2] <= acc_r14[qpm_pkg::SW-1:0];
        6'd25: s_q[3] <= acc_r14[qpm_pkg::SW-1:0];
        6'd26: hx_q <= acc_r11[SUM_W-1:0];
        6'd27: vt_q <= acc_r11[SUM_W-1:0];
        6'd29: vx_q <= {acc[qpm_pkg::CW-2:0], 1'b0};
        6'd33: vy_q <= acc[qpm_pkg::CW-1:0];
        default: ;
      endcase
    end
    if (in_acc) begin
      q_q <= q_in;
      rx_q <= sample_i.report_x;
      ry_q <= sample_i.report_y;
    end
  end

  // Whole counts out of the fraction accumulators, with saturating pending counters.
  logic signed [SUM_W-1:0] sum [2];
  logic signed [qpm_pkg::FRAC_W-1:0] frac_n [2];
  logic signed [PB-1:0] pend_n [2];

  always_comb begin
    logic [SUM_W-1:0] mag, whole_m;
    logic signed [SUM_W-1:0] whole, p;
    logic neg;
    sum[0] = SUM_W'(frac_q[0]) + hx_q + acc[SUM_W-1:0];
    sum[1] = SUM_W'(frac_q[1]) + vt_q;
    for (int k = 0; k < 2; k++) begin
      neg = sum[k][SUM_W-1];
      mag = neg ? -sum[k] : sum[k];
      whole_m = mag >> 16;
      whole = neg ? -whole_m : whole_m;
      frac_n[k] = neg ? -{1'b0, mag[15:0]} : {1'b0, mag[15:0]};
      p = SUM_W'(pend_q[k]) + whole;
      if (p > P_HI) begin
        pend_n[k] = P_HI[PB-1:0];
      end else if (p < P_LO) begin
        pend_n[k] = P_LO[PB-1:0];
      end else begin
        pend_n[k] = p[PB-1:0];
      end
    end
  end

  // Drain of pending counts into the report, held to -127..127.
  logic signed [RPT_WL-1:0] dr_new [2];
  logic signed [PB-1:0]     dr_pend [2];
  logic [1:0]               dr_moved;

  always_comb begin
    logic signed [RPT_WL-1:0] r, rc;
    logic signed [9:0] lim_pos, lim_neg, d;
    dr_moved = '0;
    for (int k = 0; k < 2; k++) begin
      r = (k == 0) ? rx_q : ry_q;
      rc = (r == -RPT_WL'(128)) ? -RPT_WL'(127) : r;
      lim_pos = 10'sd127 - 10'(rc);
      lim_neg = -10'sd127 - 10'(rc);
      if (pend_q[k] > 0) begin
        d = (pend_q[k] < PB'(lim_pos)) ? pend_q[k][9:0] : lim_pos;
      end else if (pend_q[k] < 0) begin
        d = (pend_q[k] > PB'(lim_neg)) ? pend_q[k][9:0] : lim_neg;
      end else begin
        d = '0;
      end
      if (d != 0) begin
        dr_moved = dr_moved + 2'd1;
      end
      dr_new[k] = RPT_WL'(10'(rc) + d);
      dr_pend[k] = pend_q[k] - PB'(d);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (sample_i.command == qpm_pkg::CMD_DRAIN) begin
            state_d = ST_DRAIN;
          end else if (!first_q && !sample_i.set_origin) begin
            state_d = ST_CALC;
          end
        end
      end
      ST_CALC:  if (step_q == LAST_CALC) state_d = ST_CORD;
      ST_CORD:  if (cord_done) state_d = ST_RATE;
      ST_RATE:  if (step_q == 6'd2) state_d = ST_IDLE;
      ST_DRAIN: state_d = ST_OUT;
      ST_OUT:   if (report_o.ready) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      first_q <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        prev_q[i] <= (i == 0) ? qpm_pkg::QUAT_ONE : '0;
        orig_q[i] <= (i == 0) ? qpm_pkg::QUAT_ONE : '0;
      end
      for (int k = 0; k < 2; k++) begin
        frac_q[k] <= '0;
        pend_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      step_q  <= (state_d != state_q) ? 6'd0 : step_q + 6'd1;
      if (in_acc && (sample_i.command == qpm_pkg::CMD_PUSH)) begin
        if (first_q) begin
          first_q <= 1'b0;
          prev_q  <= q_in;
          orig_q  <= q_in;
        end else if (sample_i.set_origin) begin
          orig_q <= q_in;
        end
      end
      if ((state_q == ST_RATE) && (step_q == 6'd2)) begin
        frac_q <= frac_n;
        pend_q <= pend_n;
        prev_q <= q_q;
      end
      if (state_q == ST_DRAIN) begin
        pend_q <= dr_pend;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DRAIN) begin
      nx_q    <= dr_new[0];
      ny_q    <= dr_new[1];
      moved_q <= dr_moved;
    end
  end

  assign report_o.valid      = (state_q == ST_OUT);
  assign report_o.new_x      = nx_q;
  assign report_o.new_y      = ny_q;
  assign report_o.axes_moved = moved_q;
endmodule
`default_nettype wire

[sim/quaternion_to_pointer_motion_top_tb.sv]
// Self-checking testbench for quaternion_to_pointer_motion_top: a directed table, then random
// samples and drains under several register settings, checked against a behavioral predictor.
// Depends on qpm_pkg, qpm_if and the block's RTL.
module quaternion_to_pointer_motion_top_tb;

  localparam int QW = qpm_pkg::QW;
  localparam int RPT_W = qpm_pkg::RPT_W;
  localparam int CFG_AW = qpm_pkg::CFG_AW;
  localparam int CFG_DW = qpm_pkg::CFG_DW;
  localparam int PEND_BITS = qpm_pkg::PENDING_BITS_DEF;
  localparam int ROT_STEPS = qpm_pkg::CORDIC_STEPS_DEF;
  localparam logic [CFG_AW-1:0] ADDR_DEAD_ZONE  = CFG_AW'(4 * qpm_pkg::REG_DEAD_ZONE);
  localparam logic [CFG_AW-1:0] ADDR_SPEED_GAIN = CFG_AW'(4 * qpm_pkg::REG_SPEED_GAIN);
  localparam int SETTLE_CYCLES = 100;

  typedef longint quat4_t[4];

  typedef struct {
    logic                    command;
    logic signed [QW-1:0]    w, x, y, z;
    logic                    set_origin;
    logic signed [RPT_W-1:0] rx, ry;
    bit                      typed;
    logic signed [RPT_W-1:0] ex, ey;
    logic [1:0]              em;
  } stim_row_t;

  typedef struct packed {
    logic signed [RPT_W-1:0] new_x;
    logic signed [RPT_W-1:0] new_y;
    logic [1:0]              axes_moved;
  } report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic pready;

  qpm_sample_if smp();
  qpm_report_if rpt();

  quaternion_to_pointer_motion_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .sample_i(smp), .report_o(rpt),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #10 clk_i = ~clk_i;

  // Predictor state.
  quat4_t prev_q, orig_q;
  bit     awaiting_first;
  longint frac_acc[2];
  longint pend_cnt[2];
  longint dead_zone_v, gain_v;

  report_t expected_reports[$];
  int  error_count = 0;
  bit  steady = 1'b0;
  bit  hold_req = 1'b0;
  logic signed [QW-1:0] last_q[4];

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic quat4_t conj_mul(quat4_t a, quat4_t b);
    quat4_t r;
    r[0] = a[0]*b[0] + a[1]*b[1] + a[2]*b[2] + a[3]*b[3];
    r[1] = a[0]*b[1] - a[1]*b[0] - a[2]*b[3] + a[3]*b[2];
    r[2] = a[0]*b[2] + a[1]*b[3] - a[2]*b[0] - a[3]*b[1];
    r[3] = a[0]*b[3] - a[1]*b[2] + a[2]*b[1] - a[3]*b[0];
    return r;
  endfunction

  function automatic longint yaw_atan2(longint yi, longint xi);
    longint xv, yv, zv, xs, ys;
    xv = xi; yv = yi; zv = 0;
    if (xv == 0 && yv == 0) return 0;
    if (xv < 0) begin
      if (yv >= 0) begin
        xv = yi; yv = -xi; zv = longint'(qpm_pkg::HALF_PI);
      end else begin
        xv = -yi; yv = xi; zv = -longint'(qpm_pkg::HALF_PI);
      end
    end
    for (int i = 0; i < ROT_STEPS; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (yv > 0) begin
        xv += ys; yv -= xs; zv += longint'(qpm_pkg::atan_lut(5'(i)));
      end else if (yv < 0) begin
        xv -= ys; yv += xs; zv -= longint'(qpm_pkg::atan_lut(5'(i)));
      end
    end
    return zv;
  endfunction

  function automatic void bank_counts(int k, longint sum);
    longint whole, p, hi, lo;
    hi = (longint'(1) << (PEND_BITS - 1)) - 1;
    lo = -(longint'(1) << (PEND_BITS - 1));
    whole = (sum >= 0) ? (sum >>> 16) : -((-sum) >>> 16);
    frac_acc[k] = sum - whole * 65536;
    p = pend_cnt[k] + whole;
    if (p > hi) p = hi;
    if (p < lo) p = lo;
    pend_cnt[k] = p;
  endfunction

  function automatic longint drain_axis(int k, longint r, inout int moved);
    longint p, d;
    p = pend_cnt[k];
    d = 0;
    if (r < -127) r = -127;
    if (p > 0) begin
      d = 127 - r;
      if (p < d) d = p;
    end else if (p < 0) begin
      d = -127 - r;
      if (p > d) d = p;
    end
    if (d != 0) moved++;
    pend_cnt[k] = p - d;
    return r + d;
  endfunction

  // Updates the pointer state for one accepted sample; returns 1 with a report on a drain.
  function automatic bit motion_update(stim_row_t s, output report_t rep);
    quat4_t q, rel, so;
    longint hx, vt, vx, vy, yaw;
    int moved;
    moved = 0;
    rep = '0;
    if (s.command == qpm_pkg::CMD_DRAIN) begin
      rep.new_x = RPT_W'(drain_axis(0, longint'(s.rx), moved));
      rep.new_y = RPT_W'(drain_axis(1, longint'(s.ry), moved));
      rep.axes_moved = 2'(moved);
      return 1'b1;
    end
    q[0] = s.w; q[1] = s.x; q[2] = s.y; q[3] = s.z;
    if (awaiting_first) begin
      awaiting_first = 1'b0;
      prev_q = q;
      orig_q = q;
      return 1'b0;
    end
    if (s.set_origin) begin
      orig_q = q;
      return 1'b0;
    end
    rel = conj_mul(prev_q, q);
    hx = round_shift(-rel[3] * gain_v, 11);
    vt = round_shift(-rel[1] * gain_v, 11);
    so = conj_mul(orig_q, q);
    for (int i = 0; i < 4; i++) so[i] = round_shift(so[i], 14);
    vx = 2 * (so[1]*so[2] - so[0]*so[3]);
    vy = so[0]*so[0] - so[1]*so[1] + so[2]*so[2] - so[3]*so[3];
    yaw = yaw_atan2(-vx, vy);
    if (yaw > dead_zone_v) hx += (yaw - dead_zone_v) * gain_v;
    else if (yaw < -dead_zone_v) hx += (yaw + dead_zone_v) * gain_v;
    bank_counts(0, frac_acc[0] + hx);
    bank_counts(1, frac_acc[1] + vt);
    prev_q = q;
    return 1'b0;
  endfunction

  task automatic write_reg(logic [CFG_AW-1:0] addr, logic [CFG_DW-1:0] data);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == ADDR_DEAD_ZONE) dead_zone_v = longint'(data[qpm_pkg::DZ_W-1:0]);
    else gain_v = longint'(data[qpm_pkg::G_W-1:0]);
  endtask

  task automatic wait_drained();
    while (expected_reports.size() != 0) @(posedge clk_i);
  endtask

  task automatic configure(logic [CFG_DW-1:0] dz, logic [CFG_DW-1:0] g);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(ADDR_DEAD_ZONE, dz);
    write_reg(ADDR_SPEED_GAIN, g);
  endtask

  // Offers one sample and returns once it has been transferred.
  task automatic send_sample(stim_row_t s);
    report_t rep;
    smp.valid <= 1'b1;
    smp.command <= s.command;
    smp.quat_w <= s.w; smp.quat_x <= s.x; smp.quat_y <= s.y; smp.quat_z <= s.z;
    smp.set_origin <= s.set_origin;
    smp.report_x <= s.rx; smp.report_y <= s.ry;
    do @(posedge clk_i); while (!smp.ready);
    if (motion_update(s, rep)) begin
      if (s.typed) begin
        rep.new_x = s.ex; rep.new_y = s.ey; rep.axes_moved = s.em;
      end
      expected_reports.push_back(rep);
    end
    if (s.command == qpm_pkg::CMD_PUSH) begin
      last_q[0] = s.w; last_q[1] = s.x; last_q[2] = s.y; last_q[3] = s.z;
    end
    if (!steady && $urandom_range(99) < 6) begin
      smp.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  function automatic stim_row_t random_row();
    stim_row_t s;
    int pick;
    s.typed = 1'b0; s.ex = '0; s.ey = '0; s.em = '0;
    s.command = ($urandom_range(99) < 22) ? qpm_pkg::CMD_DRAIN : qpm_pkg::CMD_PUSH;
    s.set_origin = ($urandom_range(99) < 6);
    s.rx = RPT_W'($urandom); s.ry = RPT_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 60) begin
      // Small motion from the last sample, as a real sensor delivers.
      s.w = last_q[0] + QW'($signed($urandom_range(0, 800)) - 400);
      s.x = last_q[1] + QW'($signed($urandom_range(0, 800)) - 400);
      s.y = last_q[2] + QW'($signed($urandom_range(0, 800)) - 400);
      s.z = last_q[3] + QW'($signed($urandom_range(0, 4000)) - 2000);
    end else begin
      s.w = QW'($urandom); s.x = QW'($urandom);
      s.y = QW'($urandom); s.z = QW'($urandom);
    end
    return s;
  endfunction

  // Report checking and receiver stalls.
  int hold_left = 0;
  report_t got, exp_rep;
  always @(posedge clk_i) begin
    if (rst_ni && rpt.valid && rpt.ready) begin
      got.new_x = rpt.new_x; got.new_y = rpt.new_y; got.axes_moved = rpt.axes_moved;
      if (expected_reports.size() == 0) begin
        error_count++;
        $display("%0t unexpected report transfer: %p", $time, got);
      end else begin
        exp_rep = expected_reports.pop_front();
        if (got !== exp_rep) begin
          error_count++;
          $display("%0t report mismatch: expected %p actual %p", $time, exp_rep, got);
        end
      end
    end
    if (hold_req && hold_left == 0) begin
      hold_req <= 1'b0;
      hold_left <= 400;
      rpt.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      rpt.ready <= (hold_left == 1);
    end else begin
      rpt.ready <= steady || ($urandom_range(99) >= 6);
    end
  end

  stim_row_t directed[] = '{
    // command, w, x, y, z, set_origin, report x/y, typed, expected x/y/axes
    '{qpm_pkg::CMD_DRAIN, 0, 0, 0, 0, 0, -128, 127, 1, -127, 127, 0},
    '{qpm_pkg::CMD_PUSH, 32767, -32768, 32767, -32768, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, -32768, 32767, -32768, 32767, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 16384, 0, 0, 0, 1, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 11585, 0, 0, 11585, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 11585, 0, 0, -11585, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, -16384, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 0, 0, 0, 16384, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_DRAIN, 0, 0, 0, 0, 0, 127, -127, 0, 0, 0, 0},
    '{qpm_pkg::CMD_DRAIN, 0, 0, 0, 0, 0, -127, 127, 0, 0, 0, 0},
    '{qpm_pkg::CMD_DRAIN, 0, 0, 0, 0, 0, 5, -5, 0, 0, 0, 0},
    '{qpm_pkg::CMD_PUSH, 16000, 100, -50, 300, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_DRAIN, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0},
    '{qpm_pkg::CMD_DRAIN, 0, 0, 0, 0, 0, -128, -128, 0, 0, 0, 0}
  };

  logic [CFG_DW-1:0] phase_dz[6] = '{25736, 0, 262143, 205887, 12000, 0};
  logic [CFG_DW-1:0] phase_gain[6] = '{1600, 65535, 1, 0, 40000, 300};

  initial begin
    smp.valid = 1'b0; smp.command = qpm_pkg::CMD_PUSH; smp.set_origin = 1'b0;
    smp.quat_w = '0; smp.quat_x = '0; smp.quat_y = '0; smp.quat_z = '0;
    smp.report_x = '0; smp.report_y = '0;
    rpt.ready = 1'b0;
    prev_q = '{16384, 0, 0, 0};
    orig_q = '{16384, 0, 0, 0};
    awaiting_first = 1'b1;
    frac_acc = '{0, 0};
    pend_cnt = '{0, 0};
    dead_zone_v = longint'(qpm_pkg::DEAD_ZONE_RST);
    gain_v = longint'(qpm_pkg::SPEED_GAIN_RST);
    last_q = '{16384, 0, 0, 0};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_sample(directed[i]);
    smp.valid <= 1'b0;

    for (int ph = 0; ph < 6; ph++) begin
      smp.valid <= 1'b0;
      configure(phase_dz[ph], phase_gain[ph]);
      steady = (ph == 3);
      for (int n = 0; n < 185; n++) begin
        if (ph == 1 && n == 40) hold_req = 1'b1;
        if (ph == 2 && n == 60) begin
          smp.valid <= 1'b0;
          wait_drained();
        end
        send_sample(random_row());
      end
    end
    smp.valid <= 1'b0;
    steady = 1'b0;

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end

endmodule
